// ===== sv/tksrg_pkg.sv =====
// Shared request codes, trip causes, register indexes and default widths for the risk gate.
package tksrg_pkg;

    localparam int DEF_POS_WIDTH  = 32;
    localparam int DEF_PNL_WIDTH  = 48;
    localparam int DEF_TIME_WIDTH = 48;

    localparam int REQ_W   = 3;
    localparam int CAUSE_W = 2;
    localparam int CODE_W  = 8;
    localparam int CFG_IDX_W = 2;

    typedef logic [REQ_W-1:0]     req_t;
    typedef logic [CAUSE_W-1:0]   cause_t;
    typedef logic [CODE_W-1:0]    code_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam req_t REQ_UPDATE  = 3'd0;
    localparam req_t REQ_ORDER   = 3'd1;
    localparam req_t REQ_CONFIRM = 3'd2;
    localparam req_t REQ_RESET   = 3'd3;
    localparam req_t REQ_KILL    = 3'd4;

    localparam cause_t CAUSE_NONE     = 2'd0;
    localparam cause_t CAUSE_DRAWDOWN = 2'd1;
    localparam cause_t CAUSE_MANUAL   = 2'd2;

    localparam cfg_idx_t CFG_MAX_LOSS      = 2'd0;
    localparam cfg_idx_t CFG_MAX_POSITION  = 2'd1;
    localparam cfg_idx_t CFG_STALE_TIMEOUT = 2'd2;

endpackage

// ===== sv/trading_kill_switch_risk_gate.sv =====
// Top level of the pre-trade risk gate with a latched kill switch.
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while out_ready does not stall; state is updated in the same
// cycle the result is registered. A waiting result stalls the input only once the input register
// also holds a request. Reset (rst_n low, asynchronous) clears the kill latch, flatten flag,
// cause, code, held position, last update time, all configuration registers and both valid flags.
module trading_kill_switch_risk_gate
    import tksrg_pkg::*;
#(
    parameter int POS_WIDTH  = DEF_POS_WIDTH,
    parameter int PNL_WIDTH  = DEF_PNL_WIDTH,
    parameter int TIME_WIDTH = DEF_TIME_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [((TIME_WIDTH > PNL_WIDTH-1) ?
                   ((TIME_WIDTH > POS_WIDTH-1) ? TIME_WIDTH : POS_WIDTH-1) :
                   ((PNL_WIDTH-1 > POS_WIDTH-1) ? PNL_WIDTH-1 : POS_WIDTH-1))-1:0] cfg_data,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [REQ_W-1:0]             req_type,
    input  logic signed [POS_WIDTH-1:0]  position,
    input  logic signed [PNL_WIDTH-1:0]  booked_pnl,
    input  logic signed [PNL_WIDTH-1:0]  open_pnl,
    input  logic signed [POS_WIDTH-1:0]  size_delta,
    input  logic [TIME_WIDTH-1:0]        timestamp_ms,
    input  logic                         require_flatten,
    input  logic [CODE_W-1:0]            reason_code,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         order_allowed,
    output logic                         halted,
    output logic                         killed,
    output logic                         must_flatten,
    output logic [CAUSE_W-1:0]           trip_cause,
    output logic [CODE_W-1:0]            trip_code
);

    logic [PNL_WIDTH-2:0]  max_loss_reg;
    logic [POS_WIDTH-2:0]  max_position_reg;
    logic [TIME_WIDTH-1:0] stale_timeout_reg;

    logic                  v1_reg;
    req_t                  req_reg;
    logic [POS_WIDTH-1:0]  pos_reg;
    logic [PNL_WIDTH-1:0]  rpnl_reg;
    logic [PNL_WIDTH-1:0]  upnl_reg;
    logic [POS_WIDTH-1:0]  delta_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  flat_reg;
    code_t                 reason_reg;

    logic                  kill_reg;
    logic                  kill_next;
    logic                  flatten_reg;
    logic                  flatten_next;
    logic [POS_WIDTH-1:0]  held_pos_reg;
    logic [POS_WIDTH-1:0]  held_pos_next;
    logic [TIME_WIDTH-1:0] last_time_reg;
    logic [TIME_WIDTH-1:0] last_time_next;
    cause_t                cause_reg;
    cause_t                cause_next;
    code_t                 code_reg;
    code_t                 code_next;

    logic                  out_valid_reg;
    logic                  allowed_reg;
    logic                  allowed_next;
    logic                  halted_reg;
    logic                  halted_next;

    logic                  advance;
    logic                  in_xfer;

    logic [PNL_WIDTH+1:0]  loss_sum;
    logic                  drawdown_hit;
    logic [POS_WIDTH:0]    new_pos;
    logic [POS_WIDTH:0]    new_mag;
    logic                  size_ok;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  stale;

    assign advance  = v1_reg && (!out_valid_reg || out_ready);
    assign in_ready = !v1_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    // The loss limit check is done as realized + unrealized + max_loss <= 0.
    assign loss_sum = {{2{rpnl_reg[PNL_WIDTH-1]}}, rpnl_reg}
                    + {{2{upnl_reg[PNL_WIDTH-1]}}, upnl_reg}
                    + {3'b000, max_loss_reg};
    assign drawdown_hit = loss_sum[PNL_WIDTH+1] || (loss_sum == '0);

    assign new_pos = {held_pos_reg[POS_WIDTH-1], held_pos_reg}
                   + {delta_reg[POS_WIDTH-1], delta_reg};
    assign new_mag = new_pos[POS_WIDTH] ? (~new_pos + 1'b1) : new_pos;
    assign size_ok = new_mag <= {2'b00, max_position_reg};

    assign last_time_next = ((req_reg == REQ_UPDATE) || (req_reg == REQ_RESET)) ? now_reg
                                                                                 : last_time_reg;

    // Orders never change the last update time, so the post-request time serves both uses.
    assign elapsed = now_reg - last_time_next;
    always_comb
    begin
        if (last_time_next == '0)
            stale = 1'b1;
        else if (now_reg < last_time_next)
            stale = 1'b0;
        else
            stale = elapsed > stale_timeout_reg;
    end

    always_comb
    begin
        kill_next      = kill_reg;
        flatten_next   = flatten_reg;
        held_pos_next  = held_pos_reg;
        cause_next     = cause_reg;
        code_next      = code_reg;
        allowed_next   = 1'b0;
        unique case (req_reg)
            REQ_UPDATE:
            begin
                held_pos_next  = pos_reg;
                if (!kill_reg && drawdown_hit)
                begin
                    kill_next    = 1'b1;
                    flatten_next = 1'b1;
                    cause_next   = CAUSE_DRAWDOWN;
                    code_next    = '0;
                end
            end
            REQ_ORDER:
            begin
                allowed_next = !kill_reg && !stale && size_ok;
            end
            REQ_CONFIRM:
            begin
                flatten_next = 1'b0;
            end
            REQ_RESET:
            begin
                kill_next      = 1'b0;
                flatten_next   = 1'b0;
                cause_next     = CAUSE_NONE;
                code_next      = '0;
            end
            REQ_KILL:
            begin
                if (!kill_reg)
                begin
                    kill_next  = 1'b1;
                    cause_next = CAUSE_MANUAL;
                    code_next  = reason_reg;
                    if (flat_reg)
                        flatten_next = 1'b1;
                end
            end
            default:
            begin
                allowed_next = 1'b0;
            end
        endcase
        halted_next = kill_next || stale;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_loss_reg      <= '0;
            max_position_reg  <= '0;
            stale_timeout_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_LOSS:      max_loss_reg      <= cfg_data[PNL_WIDTH-2:0];
                CFG_MAX_POSITION:  max_position_reg  <= cfg_data[POS_WIDTH-2:0];
                CFG_STALE_TIMEOUT: stale_timeout_reg <= cfg_data[TIME_WIDTH-1:0];
                default:           max_loss_reg      <= max_loss_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (in_ready)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg    <= req_type;
            pos_reg    <= position;
            rpnl_reg   <= booked_pnl;
            upnl_reg   <= open_pnl;
            delta_reg  <= size_delta;
            now_reg    <= timestamp_ms;
            flat_reg   <= require_flatten;
            reason_reg <= reason_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kill_reg      <= 1'b0;
            flatten_reg   <= 1'b0;
            held_pos_reg  <= '0;
            last_time_reg <= '0;
            cause_reg     <= CAUSE_NONE;
            code_reg      <= '0;
        end
        else if (advance)
        begin
            kill_reg      <= kill_next;
            flatten_reg   <= flatten_next;
            held_pos_reg  <= held_pos_next;
            last_time_reg <= last_time_next;
            cause_reg     <= cause_next;
            code_reg      <= code_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            allowed_reg <= allowed_next;
            halted_reg  <= halted_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign order_allowed    = allowed_reg;
    assign halted           = halted_reg;
    assign killed           = kill_reg;
    assign must_flatten     = flatten_reg;
    assign trip_cause       = cause_reg;
    assign trip_code        = code_reg;

endmodule

// ===== sv/tksrg_checker.sv =====
// Port-level assertions for the risk gate and the bind that attaches them.
module tksrg_checker
    import tksrg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               order_allowed,
    input  logic               halted,
    input  logic               killed,
    input  logic               must_flatten,
    input  logic [CAUSE_W-1:0] trip_cause,
    input  logic [CODE_W-1:0]  trip_code
);

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(order_allowed) && $stable(halted)
            && $stable(killed) && $stable(trip_cause) && $stable(trip_code))
        else $error("result changed while stalled");

    a_kill_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (killed || order_allowed) |-> (halted == killed) && !(order_allowed && halted))
        else $error("kill or allowed order inconsistent with halted");

    a_cause_kill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> killed == (trip_cause != CAUSE_NONE))
        else $error("trip cause does not match kill latch");

    a_code_manual: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (trip_code != '0) |-> trip_cause == CAUSE_MANUAL)
        else $error("trip code set without manual kill");

    a_flatten_kill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && must_flatten |-> killed)
        else $error("flatten required without kill");

endmodule

bind trading_kill_switch_risk_gate tksrg_checker u_tksrg_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .order_allowed    (order_allowed),
    .halted           (halted),
    .killed           (killed),
    .must_flatten     (must_flatten),
    .trip_cause       (trip_cause),
    .trip_code        (trip_code)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for the pre-trade risk gate: random and directed requests, verdicts checked.
module tb_top;
    import tksrg_pkg::*;

    localparam int POS_W = DEF_POS_WIDTH;
    localparam int PNL_W = DEF_PNL_WIDTH;
    localparam int TIME_W = DEF_TIME_WIDTH;
    localparam int CFG_W = (TIME_W > PNL_W - 1) ?
                           ((TIME_W > POS_W - 1) ? TIME_W : POS_W - 1) :
                           ((PNL_W - 1 > POS_W - 1) ? PNL_W - 1 : POS_W - 1);
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic signed [PNL_W-1:0] pnl_t;
    typedef logic [TIME_W-1:0] stamp_t;

    localparam pos_t POS_MIN = {1'b1, {(POS_W - 1){1'b0}}};
    localparam pos_t POS_MAX = {1'b0, {(POS_W - 1){1'b1}}};
    localparam pnl_t PNL_MIN = {1'b1, {(PNL_W - 1){1'b0}}};
    localparam pnl_t PNL_MAX = {1'b0, {(PNL_W - 1){1'b1}}};
    localparam stamp_t STAMP_MAX = '1;

    typedef struct packed {
        logic   allowed;
        logic   halted;
        logic   killed;
        logic   flatten;
        cause_t cause;
        code_t  code;
    } verdict_t;

    class gate_scoreboard;
        logic [PNL_W-2:0] max_loss;
        logic [POS_W-2:0] max_position;
        stamp_t           stale_timeout;
        logic             kill_latch;
        logic             flatten_flag;
        pos_t             held_position;
        stamp_t           last_update;
        cause_t           cause_held;
        code_t            code_held;
        verdict_t         verdict_q[$];
        int               errors;

        function new();
            max_loss = '0;
            max_position = '0;
            stale_timeout = '0;
            kill_latch = 1'b0;
            flatten_flag = 1'b0;
            held_position = '0;
            last_update = '0;
            cause_held = CAUSE_NONE;
            code_held = '0;
            errors = 0;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function logic is_stale(stamp_t now);
            if (last_update == '0)
                return 1'b1;
            if (now < last_update)
                return 1'b0;
            return (now - last_update) > stale_timeout;
        endfunction

        function void note_request(req_t kind, pos_t pos, pnl_t rpnl, pnl_t upnl, pos_t delta,
                                   stamp_t now, logic want_flat, code_t reason);
            verdict_t v;
            longint   total;
            longint   next_pos;
            longint   magnitude;
            v = '0;
            case (kind)
                REQ_UPDATE:
                begin
                    held_position = pos;
                    last_update = now;
                    total = longint'(rpnl) + longint'(upnl);
                    if (!kill_latch && total <= -longint'(max_loss))
                    begin
                        kill_latch = 1'b1;
                        flatten_flag = 1'b1;
                        cause_held = CAUSE_DRAWDOWN;
                        code_held = '0;
                    end
                end
                REQ_ORDER:
                begin
                    if (!kill_latch && !is_stale(now))
                    begin
                        next_pos = longint'(held_position) + longint'(delta);
                        magnitude = (next_pos < 0) ? -next_pos : next_pos;
                        v.allowed = magnitude <= longint'(max_position);
                    end
                end
                REQ_CONFIRM:
                begin
                    flatten_flag = 1'b0;
                end
                REQ_RESET:
                begin
                    kill_latch = 1'b0;
                    flatten_flag = 1'b0;
                    cause_held = CAUSE_NONE;
                    code_held = '0;
                    last_update = now;
                end
                REQ_KILL:
                begin
                    if (!kill_latch)
                    begin
                        kill_latch = 1'b1;
                        if (want_flat)
                            flatten_flag = 1'b1;
                        cause_held = CAUSE_MANUAL;
                        code_held = reason;
                    end
                end
                default:
                begin
                end
            endcase
            v.halted = kill_latch || is_stale(now);
            v.killed = kill_latch;
            v.flatten = flatten_flag;
            v.cause = cause_held;
            v.code = code_held;
            verdict_q.push_back(v);
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_verdict(verdict_t got);
            verdict_t want;
            if (verdict_q.size() == 0)
            begin
                report_mismatch("result with no request pending", got, 0);
                return;
            end
            want = verdict_q.pop_front();
            if (got.allowed !== want.allowed)
                report_mismatch("order_allowed", got.allowed, want.allowed);
            if (got.halted !== want.halted)
                report_mismatch("halted", got.halted, want.halted);
            if (got.killed !== want.killed)
                report_mismatch("killed", got.killed, want.killed);
            if (got.flatten !== want.flatten)
                report_mismatch("must_flatten", got.flatten, want.flatten);
            if (got.cause !== want.cause)
                report_mismatch("trip_cause", got.cause, want.cause);
            if (got.code !== want.code)
                report_mismatch("trip_code", got.code, want.code);
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    cfg_idx_t         cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    req_t             req_type = REQ_UPDATE;
    pos_t             position = '0;
    pnl_t             booked_pnl = '0;
    pnl_t             open_pnl = '0;
    pos_t             size_delta = '0;
    stamp_t           timestamp_ms = '0;
    logic             require_flatten = 1'b0;
    code_t            reason_code = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             order_allowed;
    logic             halted;
    logic             killed;
    logic             must_flatten;
    cause_t           trip_cause;
    code_t            trip_code;

    int idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    gate_scoreboard sb = new();

    trading_kill_switch_risk_gate dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .position         (position),
        .booked_pnl       (booked_pnl),
        .open_pnl         (open_pnl),
        .size_delta       (size_delta),
        .timestamp_ms     (timestamp_ms),
        .require_flatten  (require_flatten),
        .reason_code      (reason_code),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .order_allowed    (order_allowed),
        .halted           (halted),
        .killed           (killed),
        .must_flatten     (must_flatten),
        .trip_cause       (trip_cause),
        .trip_code        (trip_code)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Both transfers are sampled in one process so a request is always noted before its verdict.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(req_type, position, booked_pnl, open_pnl, size_delta,
                                timestamp_ms, require_flatten, reason_code);
            if (out_valid && out_ready)
                sb.check_verdict('{order_allowed, halted, killed, must_flatten,
                                   trip_cause, trip_code});
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic pos_t pick_position();
        int span;
        span = (sb.max_position > 100000) ? 100000 : int'(sb.max_position) + 2;
        case ($urandom_range(9))
            0: return POS_MIN;
            1: return POS_MAX;
            2, 3: return pos_t'($urandom());
            default: return pos_t'(int'($urandom_range(2 * span)) - span);
        endcase
    endfunction

    function automatic pos_t pick_delta();
        int span;
        int off;
        span = (sb.max_position > 100000) ? 100000 : int'(sb.max_position) + 2;
        off = int'($urandom_range(2)) - 1;
        case ($urandom_range(9))
            0: return POS_MIN;
            1: return POS_MAX;
            2: return pos_t'($urandom());
            3: return pos_t'(longint'(sb.max_position) - longint'(sb.held_position) + off);
            4: return pos_t'(-longint'(sb.max_position) - longint'(sb.held_position) + off);
            default: return pos_t'(int'($urandom_range(2 * span)) - span);
        endcase
    endfunction

    function automatic stamp_t pick_stamp();
        stamp_t base;
        int     win;
        base = sb.last_update;
        win = (sb.stale_timeout > 400) ? 400 :
              int'(sb.stale_timeout) + int'(sb.stale_timeout) / 4 + 2;
        case ($urandom_range(19))
            0: return '0;
            1: return stamp_t'(rand64());
            2: return STAMP_MAX;
            3: return base - stamp_t'($urandom_range(50, 1));
            4: return base + sb.stale_timeout;
            5: return base + sb.stale_timeout + 1;
            default: return base + stamp_t'($urandom_range(win));
        endcase
    endfunction

    task automatic pick_pnl(output pnl_t rp, output pnl_t up);
        case ($urandom_range(9))
            0:
            begin
                rp = PNL_MIN;
                up = pnl_t'(rand64());
            end
            1:
            begin
                rp = PNL_MAX;
                up = PNL_MAX;
            end
            2:
            begin
                rp = pnl_t'(rand64());
                up = pnl_t'(rand64());
            end
            3, 4:
            begin
                up = -pnl_t'($urandom_range(1000));
                rp = pnl_t'(-longint'(sb.max_loss) - longint'(up)
                            + longint'($urandom_range(2)) - 1);
            end
            5:
            begin
                rp = '0;
                up = '0;
            end
            default:
            begin
                rp = pnl_t'(int'($urandom_range(2000)) - 500);
                up = pnl_t'(int'($urandom_range(2000)) - 1500);
            end
        endcase
    endtask

    task automatic send_request(req_t kind, pos_t pos, pnl_t rp, pnl_t up, pos_t delta,
                                stamp_t ts, logic flat, code_t code);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        position <= pos;
        booked_pnl <= rp;
        open_pnl <= up;
        size_delta <= delta;
        timestamp_ms <= ts;
        require_flatten <= flat;
        reason_code <= code;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
    endtask

    task automatic random_request();
        int   pick;
        req_t kind;
        pnl_t rp;
        pnl_t up;
        pick = $urandom_range(99);
        if (pick < 32)
            kind = REQ_UPDATE;
        else if (pick < 70)
            kind = REQ_ORDER;
        else if (pick < 78)
            kind = REQ_CONFIRM;
        else if (pick < 88)
            kind = REQ_RESET;
        else if (pick < 94)
            kind = REQ_KILL;
        else
            kind = req_t'(REQ_KILL + $urandom_range(3, 1));
        pick_pnl(rp, up);
        send_request(kind, pick_position(), rp, up, pick_delta(), pick_stamp(),
                     logic'($urandom_range(1)), code_t'($urandom()));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic [PNL_W-2:0] ml, logic [POS_W-2:0] mp, stamp_t st);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MAX_LOSS;
        cfg_data <= CFG_W'(ml);
        @(posedge clk);
        cfg_index <= CFG_MAX_POSITION;
        cfg_data <= CFG_W'(mp);
        @(posedge clk);
        cfg_index <= CFG_STALE_TIMEOUT;
        cfg_data <= CFG_W'(st);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.max_loss = ml;
        sb.max_position = mp;
        sb.stale_timeout = st;
    endtask

    task automatic run_phase(logic [PNL_W-2:0] ml, logic [POS_W-2:0] mp, stamp_t st,
                             int idle, int stall, int n);
        drain();
        set_config(ml, mp, st);
        idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2 || $urandom_range(99) == 0)
                drain();
            random_request();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config(1000, 1000, 100);

        // The block has never seen an update, so an order is refused as stale.
        send_request(REQ_ORDER, 0, 0, 0, 5, 5, 1'b0, 8'h00);
        send_request(req_t'(REQ_KILL + 1), 7, 1, 2, 3, 10, 1'b1, 8'h5A);
        send_request(REQ_UPDATE, 0, 0, 0, 0, 0, 1'b0, 8'h00);
        send_request(REQ_UPDATE, 100, 500, -200, 0, 1000, 1'b0, 8'h00);
        send_request(REQ_ORDER, 0, 0, 0, 900, 1050, 1'b0, 8'h00);
        send_request(REQ_ORDER, 0, 0, 0, 901, 1100, 1'b0, 8'h00);
        send_request(REQ_ORDER, 0, 0, 0, -1100, 1100, 1'b0, 8'h00);
        send_request(REQ_ORDER, 0, 0, 0, 0, 1101, 1'b0, 8'h00);
        send_request(REQ_ORDER, 0, 0, 0, 0, 900, 1'b0, 8'h00);
        send_request(REQ_UPDATE, -50, -600, -400, 0, 2000, 1'b0, 8'h00);
        send_request(REQ_UPDATE, POS_MIN, PNL_MIN, PNL_MIN, 0, 2001, 1'b0, 8'h00);
        send_request(REQ_KILL, 0, 0, 0, 0, 2002, 1'b1, 8'hAB);
        send_request(REQ_ORDER, 0, 0, 0, 0, 2002, 1'b0, 8'h00);
        send_request(REQ_CONFIRM, 0, 0, 0, 0, 2003, 1'b0, 8'h00);
        send_request(REQ_RESET, 0, 0, 0, 0, 3000, 1'b0, 8'h00);
        send_request(REQ_KILL, 0, 0, 0, 0, 3001, 1'b0, 8'hFF);
        send_request(REQ_RESET, 0, 0, 0, 0, 3100, 1'b0, 8'h00);
        send_request(REQ_KILL, 0, 0, 0, 0, 3101, 1'b1, 8'h01);
        send_request(REQ_RESET, 0, 0, 0, 0, 0, 1'b0, 8'h00);
        send_request(REQ_UPDATE, POS_MIN, PNL_MAX, PNL_MAX, 0, STAMP_MAX, 1'b0, 8'h00);
        send_request(REQ_ORDER, 0, 0, 0, POS_MIN, STAMP_MAX, 1'b0, 8'h00);
        send_request(REQ_UPDATE, POS_MAX, 0, 0, 0, STAMP_MAX, 1'b0, 8'h00);
        send_request(REQ_ORDER, 0, 0, 0, POS_MAX, STAMP_MAX, 1'b0, 8'h00);
        send_request(req_t'(REQ_KILL + 3), POS_MAX, PNL_MAX, PNL_MIN, POS_MIN, STAMP_MAX,
                     1'b1, 8'hFF);

        run_phase(1000000, 5000, 200, 0, 0, 120);
        run_phase('0, '0, '0, 87, 0, 80);
        run_phase('1, '1, '1, 0, 87, 80);
        run_phase($urandom_range(5000), $urandom_range(3000), $urandom_range(300), 10, 10, 170);
        drain();

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
sv/tksrg_pkg.sv
sv/trading_kill_switch_risk_gate.sv
sv/tksrg_checker.sv
bench/tb_top.sv
